[src/mtl_pkg.sv]
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared widths, operation and status codes, and the controller/datapath
// command and status types of the merge tree ancestor engine.
// ----------------------------------------------------------------------------
package mtl_pkg;

  localparam int NODE_W = 9;
  localparam int TIME_W = 10;
  localparam int CFG_W  = 9;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_MERGE = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd1;
  localparam logic [ST_W-1:0] ST_UNBUILT = 2'd2;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_DECIDE,
    CMD_M_RDA,
    CMD_M_RDB,
    CMD_M_WR,
    CMD_B_INIT,
    CMD_B_POP,
    CMD_B_ELEM,
    CMD_B_PAR,
    CMD_B_LRD,
    CMD_B_LWR,
    CMD_B_PUSHX,
    CMD_B_CRD0,
    CMD_B_CRD1,
    CMD_B_CW,
    CMD_B_PUSH0,
    CMD_B_DONE,
    CMD_Q_RDY,
    CMD_Q_RDX,
    CMD_Q_CHKX,
    CMD_Q_LRD,
    CMD_Q_TRD,
    CMD_Q_TCHK,
    CMD_Q_PRD,
    CMD_Q_PAR,
    CMD_RESP
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic go_merge;
    logic go_build;
    logic go_query;
    logic sp_zero;
    logic is_exit;
    logic is_internal;
    logic lvl_last;
    logic lvl_zero;
    logic encl;
    logic out_free;
  } dp_status_t;

endpackage

[src/mtl_if.sv]
// ----------------------------------------------------------------------------
// mtl_req_if / mtl_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface mtl_req_if;
  import mtl_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;
  modport source (output valid, operation, first_node, second_node, input ready);
  modport sink (input valid, operation, first_node, second_node, output ready);
endinterface

interface mtl_rsp_if;
  import mtl_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;
  logic [ST_W-1:0]   status;
  modport source (output valid, ancestor, status, input ready);
  modport sink (input valid, ancestor, status, output ready);
endinterface

[src/merge_tree_lca_engine.sv]
// ----------------------------------------------------------------------------
// merge_tree_lca_engine
// Merge tree builder with binary-lifting lowest common ancestor queries.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out. A build walks all
// 2*tower_count-1 nodes and, through the single read port of the lifting
// table, fills each node's lifting entries one level at a time; a merge node
// also reads its two children and pushes them. Requests are taken one at a
// time; the response register lets a new request in while the last response
// waits. Writing tower_count restarts the merge history and needs a new build.
module merge_tree_lca_engine #(
  parameter int MAX_TOWERS  = 256,
  parameter int LIFT_LEVELS = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mtl_pkg::CFG_W-1:0] cfg_wdata,
  mtl_req_if.sink                   req,
  mtl_rsp_if.source                 rsp
);
  import mtl_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  mtl_ctrl u_ctrl (
    .clk, .rst, .st, .cmd
  );

  mtl_dpath #(.MAX_TOWERS(MAX_TOWERS), .LIFT_LEVELS(LIFT_LEVELS)) u_dpath (
    .clk, .rst, .cfg_we, .cfg_wdata, .req, .rsp, .cmd, .st
  );

endmodule

[src/mtl_ram.sv]
// ----------------------------------------------------------------------------
// mtl_ram
// Generic memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mtl_ctrl.sv]
// ----------------------------------------------------------------------------
// mtl_ctrl
// Sequencer for merge, build walk and ancestor query; issues one datapath
// command per cycle.
// ----------------------------------------------------------------------------
module mtl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  mtl_pkg::dp_status_t st,
  output mtl_pkg::cmd_t       cmd
);
  import mtl_pkg::*;

  typedef enum logic [4:0] {
    IDLE, DECIDE, M_RDA, M_RDB, M_WR,
    B_INIT, B_POP, B_ELEM, B_PAR, B_LRD, B_LWR, B_PUSHX,
    B_CRD0, B_CRD1, B_CW, B_PUSH0, B_DONE,
    Q_RDY, Q_RDX, Q_CHKX, Q_LRD, Q_TRD, Q_TCHK, Q_PRD, Q_PAR,
    RESP
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      IDLE:    if (st.in_valid) state_next = DECIDE;
      DECIDE: begin
        if (st.go_merge) state_next = M_RDA;
        else if (st.go_build) state_next = B_INIT;
        else if (st.go_query) state_next = Q_RDY;
        else state_next = RESP;
      end
      M_RDA:   state_next = M_RDB;
      M_RDB:   state_next = M_WR;
      M_WR:    state_next = RESP;
      B_INIT:  state_next = B_POP;
      B_POP:   state_next = st.sp_zero ? B_DONE : B_ELEM;
      B_ELEM:  state_next = st.is_exit ? B_POP : B_PAR;
      B_PAR:   state_next = B_LRD;
      B_LRD:   state_next = B_LWR;
      B_LWR:   state_next = st.lvl_last ? B_PUSHX : B_LRD;
      B_PUSHX: state_next = st.is_internal ? B_CRD0 : B_POP;
      B_CRD0:  state_next = B_CRD1;
      B_CRD1:  state_next = B_CW;
      B_CW:    state_next = B_PUSH0;
      B_PUSH0: state_next = B_POP;
      B_DONE:  state_next = RESP;
      Q_RDY:   state_next = Q_RDX;
      Q_RDX:   state_next = Q_CHKX;
      Q_CHKX:  state_next = st.encl ? RESP : Q_LRD;
      Q_LRD:   state_next = Q_TRD;
      Q_TRD:   state_next = Q_TCHK;
      Q_TCHK:  state_next = st.lvl_zero ? Q_PRD : Q_LRD;
      Q_PRD:   state_next = Q_PAR;
      Q_PAR:   state_next = RESP;
      RESP:    if (st.out_free) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      IDLE:    cmd = CMD_IDLE;
      DECIDE:  cmd = CMD_DECIDE;
      M_RDA:   cmd = CMD_M_RDA;
      M_RDB:   cmd = CMD_M_RDB;
      M_WR:    cmd = CMD_M_WR;
      B_INIT:  cmd = CMD_B_INIT;
      B_POP:   cmd = CMD_B_POP;
      B_ELEM:  cmd = CMD_B_ELEM;
      B_PAR:   cmd = CMD_B_PAR;
      B_LRD:   cmd = CMD_B_LRD;
      B_LWR:   cmd = CMD_B_LWR;
      B_PUSHX: cmd = CMD_B_PUSHX;
      B_CRD0:  cmd = CMD_B_CRD0;
      B_CRD1:  cmd = CMD_B_CRD1;
      B_CW:    cmd = CMD_B_CW;
      B_PUSH0: cmd = CMD_B_PUSH0;
      B_DONE:  cmd = CMD_B_DONE;
      Q_RDY:   cmd = CMD_Q_RDY;
      Q_RDX:   cmd = CMD_Q_RDX;
      Q_CHKX:  cmd = CMD_Q_CHKX;
      Q_LRD:   cmd = CMD_Q_LRD;
      Q_TRD:   cmd = CMD_Q_TRD;
      Q_TCHK:  cmd = CMD_Q_TCHK;
      Q_PRD:   cmd = CMD_Q_PRD;
      Q_PAR:   cmd = CMD_Q_PAR;
      RESP:    cmd = CMD_RESP;
      default: cmd = CMD_IDLE;
    endcase
  end

endmodule

[src/mtl_dpath.sv]
// ----------------------------------------------------------------------------
// mtl_dpath
// Tables, walk stack, counters and response register; carries out the
// command given by the sequencer each cycle.
// ----------------------------------------------------------------------------
module mtl_dpath #(
  parameter int MAX_TOWERS  = 256,
  parameter int LIFT_LEVELS = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtl_pkg::CFG_W-1:0]     cfg_wdata,
  mtl_req_if.sink                       req,
  mtl_rsp_if.source                     rsp,
  input  mtl_pkg::cmd_t                 cmd,
  output mtl_pkg::dp_status_t           st
);
  import mtl_pkg::*;

  localparam int SLOTS = 2 * MAX_TOWERS;
  localparam int TW_W  = $clog2(MAX_TOWERS);
  localparam int NA_W  = $clog2(SLOTS);
  localparam int LA_W  = $clog2(SLOTS * LIFT_LEVELS);
  localparam int MC_W  = $clog2(MAX_TOWERS);
  localparam int SP_W  = $clog2(SLOTS + 1);
  localparam int LV_W  = $clog2(LIFT_LEVELS);
  localparam int CMP_W = ((MC_W > CFG_W) ? MC_W : CFG_W) + 2;
  localparam int STK_W = NODE_W + 1;

  // registers
  logic [CFG_W-1:0]     count;
  logic [MC_W-1:0]      mcnt;
  logic                 built;
  logic [MAX_TOWERS-1:0] cur_valid;
  logic [OP_W-1:0]      op;
  logic [NODE_W-1:0]    a, b, v, x, u, lval, c_hold;
  logic                 vq;
  logic [LV_W-1:0]      lvl;
  logic [SP_W-1:0]      sp;
  logic [TIME_W-1:0]    tick, ye, yx;
  logic [NODE_W-1:0]    anc;
  logic [ST_W-1:0]      res_st;
  logic                 ovalid;
  logic [NODE_W-1:0]    oanc;
  logic [ST_W-1:0]      ost;

  // memory ports
  logic tw_we, ch_we, pa_we, lf_we, en_we, ex_we, sk_we;
  logic [TW_W-1:0]   tw_waddr, tw_raddr;
  logic [NODE_W-1:0] tw_wdata, tw_rdata;
  logic [NA_W-1:0]   ch_waddr, ch_raddr;
  logic [NODE_W-1:0] ch_wdata, ch_rdata;
  logic [NA_W-1:0]   pa_waddr, pa_raddr;
  logic [NODE_W-1:0] pa_wdata, pa_rdata;
  logic [LA_W-1:0]   lf_waddr, lf_raddr;
  logic [NODE_W-1:0] lf_wdata, lf_rdata;
  logic [NA_W-1:0]   en_waddr, en_raddr, ex_waddr, ex_raddr;
  logic [TIME_W-1:0] en_wdata, en_rdata, ex_wdata, ex_rdata;
  logic [NA_W-1:0]   sk_waddr, sk_raddr;
  logic [STK_W-1:0]  sk_wdata, sk_rdata;

  logic              cnt_ok, accept, out_free, encl;
  logic [CMP_W-1:0]  node_lim;
  logic [NODE_W-1:0] new_node, root, kb, cur_a, cur_b, e_node;

  function automatic logic [LA_W-1:0] lift_addr(input logic [NODE_W-1:0] n,
                                                 input logic [LV_W-1:0] l);
    lift_addr = LA_W'(LA_W'(n) * LA_W'(LIFT_LEVELS) + LA_W'(l));
  endfunction

  assign cnt_ok   = (count != '0) && (CMP_W'(count) <= CMP_W'(MAX_TOWERS));
  assign node_lim = CMP_W'({count, 1'b0}) - CMP_W'(1);
  assign new_node = NODE_W'(CMP_W'(count) + CMP_W'(mcnt));
  assign root     = NODE_W'(CMP_W'({count, 1'b0}) - CMP_W'(2));
  assign kb       = NODE_W'(CMP_W'(v) - CMP_W'(count));
  assign cur_a    = vq ? tw_rdata : a;
  assign cur_b    = vq ? tw_rdata : b;
  assign e_node   = sk_rdata[STK_W-1:1];
  assign encl     = (en_rdata <= ye) && (ex_rdata >= yx);
  assign out_free = !ovalid || rsp.ready;
  assign accept   = req.valid && (cmd == CMD_IDLE);

  assign req.ready    = (cmd == CMD_IDLE);
  assign rsp.valid    = ovalid;
  assign rsp.ancestor = oanc;
  assign rsp.status   = ost;

  always_comb begin
    st.in_valid    = req.valid;
    st.go_merge    = cnt_ok && (op == OP_MERGE) && (CMP_W'(a) < CMP_W'(count))
                     && (CMP_W'(b) < CMP_W'(count)) && (a != b)
                     && (CMP_W'(mcnt) + CMP_W'(1) < CMP_W'(count));
    st.go_build    = cnt_ok && (op == OP_BUILD)
                     && (CMP_W'(mcnt) + CMP_W'(1) == CMP_W'(count));
    st.go_query    = cnt_ok && (op == OP_QUERY) && built
                     && (CMP_W'(a) < node_lim) && (CMP_W'(b) < node_lim);
    st.sp_zero     = (sp == '0);
    st.is_exit     = sk_rdata[0];
    st.is_internal = CMP_W'(v) >= CMP_W'(count);
    st.lvl_last    = (lvl == LV_W'(LIFT_LEVELS - 1));
    st.lvl_zero    = (lvl == '0);
    st.encl        = encl;
    st.out_free    = out_free;
  end

  always_comb begin
    tw_we = 1'b0; tw_waddr = TW_W'(a); tw_wdata = new_node; tw_raddr = TW_W'(a);
    ch_we = 1'b0; ch_waddr = NA_W'({mcnt, 1'b0}); ch_wdata = cur_a;
    ch_raddr = NA_W'({kb, 1'b0});
    pa_we = 1'b0; pa_waddr = NA_W'(root); pa_wdata = root; pa_raddr = NA_W'(x);
    lf_we = 1'b0; lf_waddr = lift_addr(v, '0); lf_wdata = pa_rdata;
    lf_raddr = lift_addr(x, lvl);
    en_we = 1'b0; en_waddr = NA_W'(e_node); en_wdata = tick; en_raddr = NA_W'(x);
    ex_we = 1'b0; ex_waddr = NA_W'(e_node); ex_wdata = tick; ex_raddr = NA_W'(x);
    sk_we = 1'b0; sk_waddr = NA_W'(sp); sk_wdata = {v, 1'b1};
    sk_raddr = NA_W'(sp - SP_W'(1));
    case (cmd)
      CMD_M_RDB: begin
        tw_raddr = TW_W'(b);
        ch_we    = 1'b1;
      end
      CMD_M_WR: begin
        ch_we    = 1'b1;
        ch_waddr = NA_W'({mcnt, 1'b1});
        ch_wdata = cur_b;
        tw_we    = 1'b1;
      end
      CMD_B_INIT: begin
        pa_we    = 1'b1;
        sk_we    = 1'b1;
        sk_waddr = '0;
        sk_wdata = {root, 1'b0};
      end
      CMD_B_ELEM: begin
        en_we    = !sk_rdata[0];
        ex_we    = sk_rdata[0];
        pa_raddr = NA_W'(e_node);
      end
      CMD_B_PAR: begin
        lf_we = 1'b1;
      end
      CMD_B_LRD: begin
        lf_raddr = lift_addr(lval, LV_W'(lvl - LV_W'(1)));
      end
      CMD_B_LWR: begin
        lf_we    = 1'b1;
        lf_waddr = lift_addr(v, lvl);
        lf_wdata = lf_rdata;
      end
      CMD_B_PUSHX: begin
        sk_we = 1'b1;
      end
      CMD_B_CRD1: begin
        ch_raddr = NA_W'({kb, 1'b1});
        pa_we    = 1'b1;
        pa_waddr = NA_W'(ch_rdata);
        pa_wdata = v;
      end
      CMD_B_CW: begin
        pa_we    = 1'b1;
        pa_waddr = NA_W'(ch_rdata);
        pa_wdata = v;
        sk_we    = 1'b1;
        sk_wdata = {ch_rdata, 1'b0};
      end
      CMD_B_PUSH0: begin
        sk_we    = 1'b1;
        sk_wdata = {c_hold, 1'b0};
      end
      CMD_Q_RDY: begin
        en_raddr = NA_W'(b);
        ex_raddr = NA_W'(b);
      end
      CMD_Q_TRD: begin
        en_raddr = NA_W'(lf_rdata);
        ex_raddr = NA_W'(lf_rdata);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= CFG_W'(1);
      mcnt      <= '0;
      built     <= 1'b0;
      cur_valid <= '0;
      sp        <= '0;
      ovalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        count     <= cfg_wdata;
        mcnt      <= '0;
        built     <= 1'b0;
        cur_valid <= '0;
      end
      if (cmd == CMD_RESP && out_free) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      case (cmd)
        CMD_M_WR: begin
          mcnt                <= MC_W'(mcnt + MC_W'(1));
          built               <= 1'b0;
          cur_valid[TW_W'(a)] <= 1'b1;
        end
        CMD_B_INIT:  sp <= SP_W'(1);
        CMD_B_POP:   if (sp != '0) sp <= SP_W'(sp - SP_W'(1));
        CMD_B_PUSHX: sp <= SP_W'(sp + SP_W'(1));
        CMD_B_CW:    sp <= SP_W'(sp + SP_W'(1));
        CMD_B_PUSH0: sp <= SP_W'(sp + SP_W'(1));
        CMD_B_DONE:  built <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req.operation;
      a  <= req.first_node;
      b  <= req.second_node;
    end
    if (cmd == CMD_RESP && out_free) begin
      oanc <= anc;
      ost  <= res_st;
    end
    case (cmd)
      CMD_DECIDE: begin
        anc    <= '0;
        res_st <= (cnt_ok && op == OP_QUERY && !built) ? ST_UNBUILT : ST_BAD;
        x      <= a;
      end
      CMD_M_RDA: vq <= cur_valid[TW_W'(a)];
      CMD_M_RDB: vq <= cur_valid[TW_W'(b)];
      CMD_M_WR: begin
        anc    <= new_node;
        res_st <= ST_OK;
      end
      CMD_B_INIT: tick <= '0;
      CMD_B_ELEM: begin
        v    <= e_node;
        tick <= TIME_W'(tick + TIME_W'(1));
      end
      CMD_B_PAR: begin
        lval <= pa_rdata;
        lvl  <= LV_W'(1);
      end
      CMD_B_LWR: begin
        lval <= lf_rdata;
        lvl  <= LV_W'(lvl + LV_W'(1));
      end
      CMD_B_CRD1: c_hold <= ch_rdata;
      CMD_B_DONE: begin
        anc    <= '0;
        res_st <= ST_OK;
      end
      CMD_Q_RDX: begin
        ye <= en_rdata;
        yx <= ex_rdata;
      end
      CMD_Q_CHKX: begin
        if (encl) begin
          anc    <= x;
          res_st <= ST_OK;
        end
        lvl <= LV_W'(LIFT_LEVELS - 1);
      end
      CMD_Q_TRD: u <= lf_rdata;
      CMD_Q_TCHK: begin
        if (!encl) x <= u;
        lvl <= LV_W'(lvl - LV_W'(1));
      end
      CMD_Q_PAR: begin
        anc    <= pa_rdata;
        res_st <= ST_OK;
      end
      default: begin
      end
    endcase
  end

  mtl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_TOWERS)) u_tower (
    .clk, .we(tw_we), .waddr(tw_waddr), .wdata(tw_wdata), .raddr(tw_raddr), .rdata(tw_rdata)
  );
  mtl_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_child (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata), .raddr(ch_raddr), .rdata(ch_rdata)
  );
  mtl_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_parent (
    .clk, .we(pa_we), .waddr(pa_waddr), .wdata(pa_wdata), .raddr(pa_raddr), .rdata(pa_rdata)
  );
  mtl_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS * LIFT_LEVELS)) u_lift (
    .clk, .we(lf_we), .waddr(lf_waddr), .wdata(lf_wdata), .raddr(lf_raddr), .rdata(lf_rdata)
  );
  mtl_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_entry (
    .clk, .we(en_we), .waddr(en_waddr), .wdata(en_wdata), .raddr(en_raddr), .rdata(en_rdata)
  );
  mtl_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_exit (
    .clk, .we(ex_we), .waddr(ex_waddr), .wdata(ex_wdata), .raddr(ex_raddr), .rdata(ex_rdata)
  );
  mtl_ram #(.WIDTH(STK_W), .DEPTH(SLOTS)) u_stack (
    .clk, .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata), .raddr(sk_raddr), .rdata(sk_rdata)
  );

endmodule
